// ----- src/yadj_pkg.sv -----
`timescale 1ns / 1ps

package yadj_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_HUE      = 2'd0,
    REG_SAT      = 2'd1,
    REG_BRIGHT   = 2'd2,
    REG_CONTRAST = 2'd3
  } cfg_reg_t;

  // one pixel of three 8-bit samples (yuv in, adjusted yuv between stages)
  typedef struct packed {
    logic [7:0] v;
    logic [7:0] u;
    logic [7:0] y;
  } yuv_t;

  // one converted pixel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // coefficients derived from the configuration registers
  typedef struct packed {
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic signed [15:0] gain;
    logic signed [7:0]  contrast;
    logic signed [7:0]  brightness;
  } yadj_cfg_t;

  // floor(n / 100) as (n + LUMA_BIAS) * LUMA_RECIP >> LUMA_SHIFT, minus LUMA_BIAS / 100
  localparam logic signed [16:0] LUMA_BIAS  = 17'sd16400;
  localparam logic [31:0]        LUMA_RECIP = 32'd41944;
  localparam int                 LUMA_SHIFT = 22;

  // floor(n / 10000) the same way, after the shift by 14
  localparam logic signed [39:0] CHROMA_BIAS  = 40'sd4200000;
  localparam logic [47:0]        CHROMA_RECIP = 48'd13743896;
  localparam int                 CHROMA_SHIFT = 37;

  // bt.601 coefficients
  localparam logic [18:0]        COEF_Y  = 19'd1192;
  localparam logic signed [19:0] COEF_RV = 20'sd1634;
  localparam logic signed [19:0] COEF_GV = 20'sd833;
  localparam logic signed [19:0] COEF_GU = 20'sd400;
  localparam logic signed [19:0] COEF_BU = 20'sd2066;
  localparam logic [7:0]         LUMA_FLOOR = 8'd16;

  // round(sin(d) * 16384) for d = 0..90 degrees
  localparam logic [14:0] SIN_TABLE [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15965, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // sine of a whole degree in q1.14, 0..90
  function automatic logic [14:0] sin_q14(input logic [6:0] deg);
    logic [14:0] s;
    s = 15'd0;
    if (deg <= 7'd90) begin
      s = SIN_TABLE[deg];
    end
    return s;
  endfunction

  // clamp a signed sample to 0..255
  function automatic logic [7:0] clamp_u8(input logic signed [11:0] x);
    logic [7:0] r;
    if (x < 12'sd0) begin
      r = 8'd0;
    end else if (x > 12'sd255) begin
      r = 8'hff;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // clamp a sum to 0..262143 and keep bits 17..10
  function automatic logic [7:0] rgb_channel(input logic signed [20:0] s);
    logic [7:0] r;
    if (s < 21'sd0) begin
      r = 8'd0;
    end else if (s > 21'sd262143) begin
      r = 8'hff;
    end else begin
      r = s[17:10];
    end
    return r;
  endfunction

endpackage

// ----- src/yuv_adjust_to_rgb_pixel.sv -----
// Per-pixel contrast, brightness, hue and saturation adjustment followed by
// bt.601 yuv to rgb conversion. One pixel request is accepted on every clock
// while the output takes results, and each result passes through seven
// register stages (input, hue products, gain product, divide by reciprocal,
// adjust clamp, coefficient products, output). A stall at the output fills
// the bubbles in the pipeline before it holds off new requests.
// Write the configuration registers only while no pixel is in flight; a new
// value applies to pixels accepted from the next clock on.
`timescale 1ns / 1ps

module yuv_adjust_to_rgb_pixel (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // pixel requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // luma, chroma_blue, chroma_red
  // rgb results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red, green, blue
);
  import yadj_pkg::*;

  // configuration registers
  logic signed [7:0] hue_degrees;
  logic signed [7:0] saturation_percent;
  logic signed [7:0] brightness_offset;
  logic signed [7:0] contrast_percent;

  // hue angle folding into the quarter-wave table
  logic [7:0]         hue_abs;
  logic [6:0]         cos_idx, sin_idx;
  logic               cos_neg;
  logic signed [15:0] cos_mag, sin_mag;
  yadj_cfg_t          cfg;

  // input stage
  logic   v1, en1;
  yuv_t   pix1;
  logic   adj_ready, adj_valid, cnv_ready;
  yuv_t   adj_pix;
  rgb_t   rgb;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_degrees        <= 8'sd0;
      saturation_percent <= 8'sd100;
      brightness_offset  <= 8'sd0;
      contrast_percent   <= 8'sd100;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HUE:      hue_degrees        <= cfg_wdata;
        REG_SAT:      saturation_percent <= cfg_wdata;
        REG_BRIGHT:   brightness_offset  <= cfg_wdata;
        REG_CONTRAST: contrast_percent   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // cosine and sine from the table by symmetry
  assign hue_abs = hue_degrees[7] ? (~hue_degrees + 8'd1) : hue_degrees;

  always_comb begin
    if (hue_abs <= 8'd90) begin
      cos_idx = 7'(8'd90 - hue_abs);
      sin_idx = hue_abs[6:0];
      cos_neg = 1'b0;
    end else begin
      cos_idx = 7'(hue_abs - 8'd90);
      sin_idx = 7'(8'd180 - hue_abs);
      cos_neg = 1'b1;
    end
  end

  assign cos_mag = $signed({1'b0, sin_q14(cos_idx)});
  assign sin_mag = $signed({1'b0, sin_q14(sin_idx)});

  // derived coefficients, registered from the configuration registers
  always_ff @(posedge clk) begin
    cfg.cos_q      <= cos_neg ? -cos_mag : cos_mag;
    cfg.sin_q      <= hue_degrees[7] ? -sin_mag : sin_mag;
    cfg.gain       <= 16'(contrast_percent) * 16'(saturation_percent);
    cfg.contrast   <= contrast_percent;
    cfg.brightness <= brightness_offset;
  end

  // input register
  assign en1 = !v1 || adj_ready;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pix1.y <= s_tdata[7:0];
      pix1.u <= s_tdata[15:8];
      pix1.v <= s_tdata[23:16];
    end
  end

  // color adjustment
  yadj_adjust u_adjust (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (v1),
    .in_ready  (adj_ready),
    .in_pix    (pix1),
    .out_valid (adj_valid),
    .out_ready (cnv_ready),
    .out_pix   (adj_pix)
  );

  // rgb conversion and output register
  yadj_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (adj_valid),
    .in_ready  (cnv_ready),
    .in_pix    (adj_pix),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (rgb)
  );

  assign m_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule

// ----- src/yadj_adjust.sv -----
`timescale 1ns / 1ps

module yadj_adjust (
  input  logic                clk,
  input  logic                rst,
  input  yadj_pkg::yadj_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  yadj_pkg::yuv_t      in_pix,
  output logic                out_valid,
  input  logic                out_ready,
  output yadj_pkg::yuv_t      out_pix
);
  import yadj_pkg::*;

  // stage valids and enables
  logic v2, v3, v4, v5;
  logic en2, en3, en4, en5;

  // stage 2: offset samples times contrast and hue terms
  logic signed [8:0]  dy, du, dv;
  logic signed [16:0] ny2;
  logic signed [23:0] pu0, pu1, pv0, pv1;

  // stage 3: gain product and luma reciprocal product
  logic signed [16:0] ny_biased;
  logic signed [23:0] tu, tv;
  logic [31:0]        my3;
  logic signed [39:0] ru3, rv3;

  // stage 4: chroma reciprocal product and luma quotient
  logic signed [39:0] su, sv;
  logic [23:0]        mu, mv;
  logic [9:0]         qy4;
  logic [47:0]        mu4, mv4;

  // stage 5: adjusted samples
  logic signed [11:0] ys, us, vs;

  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign in_ready = en2;

  assign dy = $signed({1'b0, in_pix.y}) - 9'sd128;
  assign du = $signed({1'b0, in_pix.u}) - 9'sd128;
  assign dv = $signed({1'b0, in_pix.v}) - 9'sd128;

  assign ny_biased = ny2 + LUMA_BIAS;
  assign tu = pu0 + pu1;
  assign tv = pv0 - pv1;

  // floor shift by 14, then bias to a nonnegative value
  assign su = (ru3 >>> 14) + CHROMA_BIAS;
  assign sv = (rv3 >>> 14) + CHROMA_BIAS;
  assign mu = su[23:0];
  assign mv = sv[23:0];

  assign ys = $signed({2'b00, qy4}) + 12'(cfg.brightness) - 12'sd36;
  assign us = $signed({1'b0, mu4[47:CHROMA_SHIFT]}) - 12'sd292;
  assign vs = $signed({1'b0, mv4[47:CHROMA_SHIFT]}) - 12'sd292;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en2) v2 <= in_valid;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en2) begin
      ny2 <= 17'(dy) * 17'(cfg.contrast);
      pu0 <= 24'(du) * 24'(cfg.cos_q);
      pu1 <= 24'(dv) * 24'(cfg.sin_q);
      pv0 <= 24'(dv) * 24'(cfg.cos_q);
      pv1 <= 24'(du) * 24'(cfg.sin_q);
    end
    if (en3) begin
      my3 <= 32'(ny_biased[15:0]) * LUMA_RECIP;
      ru3 <= 40'(tu) * 40'(cfg.gain);
      rv3 <= 40'(tv) * 40'(cfg.gain);
    end
    if (en4) begin
      qy4 <= my3[31:LUMA_SHIFT];
      mu4 <= 48'(mu) * CHROMA_RECIP;
      mv4 <= 48'(mv) * CHROMA_RECIP;
    end
    if (en5) begin
      out_pix.y <= clamp_u8(ys);
      out_pix.u <= clamp_u8(us);
      out_pix.v <= clamp_u8(vs);
    end
  end

  assign out_valid = v5;

endmodule

// ----- src/yadj_convert.sv -----
`timescale 1ns / 1ps

module yadj_convert (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  yadj_pkg::yuv_t in_pix,
  output logic           out_valid,
  input  logic           out_ready,
  output yadj_pkg::rgb_t out_pix
);
  import yadj_pkg::*;

  logic v6, v7;
  logic en6, en7;

  // stage 6: coefficient products
  logic [7:0]         yy;
  logic signed [7:0]  uu, vv;
  logic [18:0]        py6;
  logic signed [19:0] pr6, pgv6, pgu6, pb6;

  // stage 7: sums, clamp and scale
  logic signed [20:0] ys, sr, sg, sb;

  assign en7 = !v7 || out_ready;
  assign en6 = !v6 || en7;
  assign in_ready = en6;

  // luma minus 16 floored at zero, chroma minus 128
  assign yy = (in_pix.y >= LUMA_FLOOR) ? (in_pix.y - LUMA_FLOOR) : 8'd0;
  assign uu = $signed({~in_pix.u[7], in_pix.u[6:0]});
  assign vv = $signed({~in_pix.v[7], in_pix.v[6:0]});

  assign ys = 21'($signed({1'b0, py6}));
  assign sr = ys + 21'(pr6);
  assign sg = ys - 21'(pgv6) - 21'(pgu6);
  assign sb = ys + 21'(pb6);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en6) v6 <= in_valid;
      if (en7) v7 <= v6;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en6) begin
      py6  <= 19'(yy) * COEF_Y;
      pr6  <= 20'(vv) * COEF_RV;
      pgv6 <= 20'(vv) * COEF_GV;
      pgu6 <= 20'(uu) * COEF_GU;
      pb6  <= 20'(uu) * COEF_BU;
    end
    if (en7) begin
      out_pix.red   <= rgb_channel(sr);
      out_pix.green <= rgb_channel(sg);
      out_pix.blue  <= rgb_channel(sb);
    end
  end

  assign out_valid = v7;

endmodule

// ----- tb/sv/yuv_rgb_checker.sv -----
`timescale 1ns / 1ps

module yuv_rgb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // luma, chroma_blue, chroma_red
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // red, green, blue
  output int          in_flight,
  output int          failures
);
  import yadj_pkg::*;

  // chroma gain is contrast * saturation over 100 * 100, after the q1.14 rotation
  localparam longint CHROMA_DIVISOR = 64'd163840000;

  // round(sin(d) * 16384) for whole degrees 0..90
  localparam int SINE_Q14 [0:90] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15965, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // shadow copy of the adjustment registers
  logic signed [7:0] hue_deg;
  logic signed [7:0] sat_pct;
  logic signed [7:0] bright_ofs;
  logic signed [7:0] contrast_pct;

  // rgb pixels still owed by the block, oldest first
  rgb_t owed_rgb [$];

  string chan_name [3] = '{"red", "green", "blue"};

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
    longint r;
    r = x;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // clamp a weighted sum to 18 bits and keep the top byte
  function automatic logic [7:0] to_channel(input longint sum);
    longint c;
    c = clamp_range(sum, 0, 262143);
    return 8'(c >> 10);
  endfunction

  // adjust luma and chroma, then bt.601 conversion
  function automatic rgb_t convert_pixel(input yuv_t px);
    int     h;
    int     mag;
    longint c;
    longint s;
    longint b;
    longint cq;
    longint sq;
    longint gain;
    longint du;
    longint dv;
    longint t;
    longint ya;
    longint ua;
    longint va;
    longint yy;
    rgb_t   res;
    h = hue_deg;
    c = contrast_pct;
    s = sat_pct;
    b = bright_ofs;
    mag = (h < 0) ? -h : h;
    // cosine and sine of the hue by quadrant symmetry
    if (mag <= 90) begin
      cq = SINE_Q14[90 - mag];
      sq = SINE_Q14[mag];
    end else begin
      cq = -SINE_Q14[mag - 90];
      sq = SINE_Q14[180 - mag];
    end
    if (h < 0) begin
      sq = -sq;
    end
    // luma contrast around 128 plus brightness
    ya = clamp_range(floor_quot((longint'(px.y) - 128) * c, 100) + b + 128, 0, 255);
    // chroma rotation and gain
    du = longint'(px.u) - 128;
    dv = longint'(px.v) - 128;
    gain = c * s;
    t = du * cq + dv * sq;
    ua = clamp_range(floor_quot(t * gain, CHROMA_DIVISOR) + 128, 0, 255);
    t = dv * cq - du * sq;
    va = clamp_range(floor_quot(t * gain, CHROMA_DIVISOR) + 128, 0, 255);
    // bt.601 with coefficients scaled by 1024
    yy = (ya > 16) ? ya - 16 : 0;
    res.red   = to_channel(1192 * yy + 1634 * (va - 128));
    res.green = to_channel(1192 * yy - 833 * (va - 128) - 400 * (ua - 128));
    res.blue  = to_channel(1192 * yy + 2066 * (ua - 128));
    return res;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin : watch
    rgb_t want;
    rgb_t got;
    if (rst) begin
      hue_deg      <= 8'sd0;
      sat_pct      <= 8'sd100;
      bright_ofs   <= 8'sd0;
      contrast_pct <= 8'sd100;
      owed_rgb.delete();
      in_flight <= 0;
      failures  = 0;
    end else begin
      // compare a result with the oldest owed pixel
      if (m_tvalid && m_tready) begin
        got = rgb_t'(m_tdata);
        if (owed_rgb.size() == 0) begin
          $display("%0t: rgb result %h with no request waiting, expected none", $time, got);
          failures = failures + 1;
        end else begin
          want = owed_rgb.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (got[8*k +: 8] !== want[8*k +: 8]) begin
              $display("%0t: %s expected %0d got %0d", $time, chan_name[k],
                       want[8*k +: 8], got[8*k +: 8]);
              failures = failures + 1;
            end
          end
        end
      end
      // predict with the settings in force before this edge
      if (s_tvalid && s_tready) begin
        owed_rgb.push_back(convert_pixel(yuv_t'(s_tdata)));
      end
      in_flight <= owed_rgb.size();
      // register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_HUE:      hue_deg      <= cfg_wdata;
          REG_SAT:      sat_pct      <= cfg_wdata;
          REG_BRIGHT:   bright_ofs   <= cfg_wdata;
          REG_CONTRAST: contrast_pct <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/tb_yuv_adjust_to_rgb_pixel.sv -----
`timescale 1ns / 1ps

module tb_yuv_adjust_to_rgb_pixel;
  import yadj_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 148;
  localparam int SETTLE_TICKS = 12;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_HUE;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = 24'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;

  bit idle_on = 1'b1;
  int cycles  = 0;
  int in_flight;
  int failures;

  yuv_adjust_to_rgb_pixel uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  yuv_rgb_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .in_flight (in_flight),
    .failures  (failures)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // rgb side: random stall before each result while idle_on is set
  initial begin : rgb_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  function automatic yuv_t pixel_of(input logic [7:0] y, input logic [7:0] u,
                                    input logic [7:0] v);
    yuv_t px;
    px.y = y;
    px.u = u;
    px.v = v;
    return px;
  endfunction

  // sample with extra weight on the ends and the midpoint
  function automatic logic [7:0] rand_sample();
    logic [7:0] r;
    case ($urandom_range(0, 7))
      0:       r = 8'd0;
      1:       r = 8'd255;
      2:       r = 8'd128;
      default: r = 8'($urandom);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_setting();
    logic [7:0] r;
    case ($urandom_range(0, 5))
      0:       r = 8'h80;
      1:       r = 8'h7f;
      2:       r = 8'h00;
      default: r = 8'($urandom);
    endcase
    return r;
  endfunction

  // one pixel request after an optional gap
  task automatic send_pixel(input yuv_t px);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off requests until every owed pixel is back
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  // write all four registers on back-to-back clocks
  task automatic apply_settings(input logic [7:0] hue, input logic [7:0] sat,
                                input logic [7:0] bright, input logic [7:0] contrast);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HUE;
    cfg_wdata <= hue;
    @(posedge clk);
    cfg_index <= REG_SAT;
    cfg_wdata <= sat;
    @(posedge clk);
    cfg_index <= REG_BRIGHT;
    cfg_wdata <= bright;
    @(posedge clk);
    cfg_index <= REG_CONTRAST;
    cfg_wdata <= contrast;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sample extremes, black level edge and neutral gray
  task automatic send_corners();
    send_pixel(pixel_of(8'd0,   8'd0,   8'd0));
    send_pixel(pixel_of(8'd255, 8'd255, 8'd255));
    send_pixel(pixel_of(8'd255, 8'd0,   8'd255));
    send_pixel(pixel_of(8'd0,   8'd255, 8'd0));
    send_pixel(pixel_of(8'd16,  8'd128, 8'd128));
    send_pixel(pixel_of(8'd15,  8'd128, 8'd128));
    send_pixel(pixel_of(8'd128, 8'd128, 8'd128));
    send_pixel(pixel_of(8'd235, 8'd16,  8'd240));
  endtask

  // stimulus and verdict
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, then negative gains with extreme hue and brightness
    send_corners();
    pause_until_drained();
    apply_settings(8'h80, 8'h80, 8'h7f, 8'h80);
    send_corners();

    // random pixels under a new setting per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pause_until_drained();
      case (ph)
        0:       apply_settings(8'h7f, 8'h7f, 8'h7f, 8'h7f);
        1:       apply_settings(8'd90, 8'h80, 8'h80, 8'h7f);
        2:       apply_settings(8'ha6, 8'h00, 8'h00, 8'h00);
        default: apply_settings(pick_setting(), pick_setting(), pick_setting(),
                                pick_setting());
      endcase
      idle_on = (ph % 3) != 2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          pause_until_drained();
        end
        send_pixel(pixel_of(rand_sample(), rand_sample(), rand_sample()));
      end
    end

    pause_until_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (failures == 0 && in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
